// File: design/ckfi_pkg.sv
// ----------------------------------------------------------------------------
// ckfi_pkg
// shared codes, command and status types for the keyframe interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ckfi_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_COUNT = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [3:0] CH_FOCAL   = 4'd6;
    localparam logic [3:0] CH_SENSX   = 4'd7;
    localparam logic [3:0] CH_SENSY   = 4'd8;
    localparam logic [3:0] CH_LAST    = 4'd12;
    localparam logic [3:0] WORD_TIME  = 4'd13;
    localparam int         NUM_CHANS  = 13;

    localparam logic [16:0] FRAC_ONE  = 17'h10000;

    typedef struct packed {
        logic       in_ready;
        logic       rd_en;
        logic [7:0] rd_key;
        logic [3:0] rd_word;
        logic       cap_total;
        logic       mod_start;
        logic       take_mod;
        logic       cap_t0;
        logic       cap_t1;
        logic       zero_frac;
        logic       frac_start;
        logic       take_frac;
        logic       cap_a;
        logic       mul;
        logic       acc;
        logic [3:0] chan;
        logic       foc_mul;
        logic       foc_start;
        logic       take_foc;
        logic       out_load;
    } t_ckfi_cmd;

    typedef struct packed {
        logic [8:0] n;
        logic       total_pos;
        logic       loop_en;
        logic       t_ge_total;
        logic       key_gt;
        logic       t1_le_t0;
        logic       div_done;
        logic       sensx_pos;
        logic       out_free;
    } t_ckfi_sts;

endpackage

`default_nettype wire

// File: design/ckfi_if.sv
// ----------------------------------------------------------------------------
// ckfi_if
// valid/ready channels of the keyframe interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ckfi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [2:0]         track;
    logic [3:0]         key_index;
    logic [3:0]         channel;
    logic signed [31:0] word;
    logic [4:0]         key_count;
    logic signed [31:0] query_time;
    logic [15:0]        sensor_width;
    logic [15:0]        sensor_height;
    modport source (output valid, kind, track, key_index, channel, word, key_count,
                    query_time, sensor_width, sensor_height, input ready);
    modport sink (input valid, kind, track, key_index, channel, word, key_count,
                  query_time, sensor_width, sensor_height, output ready);
endinterface

interface ckfi_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_channel;
    logic signed [31:0] out_value;
    logic               last;
    modport source (output valid, out_channel, out_value, last, input ready);
    modport sink (input valid, out_channel, out_value, last, output ready);
endinterface

interface ckfi_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/camera_keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// camera_keyframe_interpolator
// piecewise linear camera keyframe evaluation over per-track key tables
// ----------------------------------------------------------------------------
// channel   dir   role
// i_in      in    load key word, set key count, or query (kind)
// o_out     out   13 channel results per query, last on the final one
// i_cfg     in    loop enable register
//
// loads are taken only while the sequencer is idle; a query's length grows with
// n keys and is set by the key search over the one memory read port and the
// 64 step divider, used for the time wrap, the fraction (skipped when a key is
// held) and the focal rescale; a query on an empty track goes straight to output
// every query ends with 13 results through a single output register
// reset clears track counts and loop enable; key memory is not cleared
// output stalls hold the sequencer only in its output phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module camera_keyframe_interpolator
    import ckfi_pkg::*;
#(
    parameter int TRACK_COUNT    = 4,
    parameter int KEYS_PER_TRACK = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ckfi_in_if.sink    i_in,
    ckfi_out_if.source o_out,
    ckfi_cfg_if.sink   i_cfg
);

    t_ckfi_cmd cmd;
    t_ckfi_sts sts;

    assign i_in.ready  = cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    ckfi_ctrl #(
        .KEYS_PER_TRACK (KEYS_PER_TRACK)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ckfi_dp #(
        .TRACK_COUNT    (TRACK_COUNT),
        .KEYS_PER_TRACK (KEYS_PER_TRACK)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .i_kind          (i_in.kind),
        .i_track         (i_in.track),
        .i_key_index     (i_in.key_index),
        .i_channel       (i_in.channel),
        .i_word          (i_in.word),
        .i_key_count     (i_in.key_count),
        .i_query_time    (i_in.query_time),
        .i_sensor_width  (i_in.sensor_width),
        .i_sensor_height (i_in.sensor_height),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_out_channel   (o_out.out_channel),
        .o_out_value     (o_out.out_value),
        .o_last          (o_out.last),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

`default_nettype wire

// File: design/ckfi_div.sv
// ----------------------------------------------------------------------------
// ckfi_div
// restoring divider, one quotient bit per cycle, 64 by 33 bits unsigned
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ckfi_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [32:0] i_divisor,
    output logic      [63:0] o_quot,
    output logic      [32:0] o_rem,
    output logic             o_done
);

    logic [63:0] r_q;
    logic [33:0] r_r;
    logic [32:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] diff;

    assign diff = {1'b0, r_r[32:0], r_q[63]} - {2'b00, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_d   <= i_divisor;
            r_cnt <= 6'd63;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (!diff[34]) begin
                r_r <= diff[33:0];
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= {r_r[32:0], r_q[63]};
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r[32:0];
    assign o_done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a busy cycle");

endmodule

`default_nettype wire

// File: design/ckfi_ctrl.sv
// ----------------------------------------------------------------------------
// ckfi_ctrl
// query sequencer: wrap, key search, fraction, channel sweep, focal, output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ckfi_ctrl
    import ckfi_pkg::*;
#(
    parameter int KEYS_PER_TRACK = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_in_kind,
    input  wire t_ckfi_sts  i_sts,
    output t_ckfi_cmd       o_cmd
);

    localparam int KW = $clog2(KEYS_PER_TRACK);

    localparam logic [4:0] IDLE      = 5'd0;
    localparam logic [4:0] Q_CNT     = 5'd1;
    localparam logic [4:0] Q_TOT     = 5'd2;
    localparam logic [4:0] M_START   = 5'd3;
    localparam logic [4:0] M_WAIT    = 5'd4;
    localparam logic [4:0] S_RD      = 5'd5;
    localparam logic [4:0] S_CMP     = 5'd6;
    localparam logic [4:0] R_T0      = 5'd7;
    localparam logic [4:0] R_T1      = 5'd8;
    localparam logic [4:0] R_DEC     = 5'd9;
    localparam logic [4:0] F_START   = 5'd10;
    localparam logic [4:0] F_WAIT    = 5'd11;
    localparam logic [4:0] C_RA      = 5'd12;
    localparam logic [4:0] C_RB      = 5'd13;
    localparam logic [4:0] C_MUL     = 5'd14;
    localparam logic [4:0] C_ACC     = 5'd15;
    localparam logic [4:0] FOC_CHK   = 5'd16;
    localparam logic [4:0] FOC_START = 5'd17;
    localparam logic [4:0] FOC_WAIT  = 5'd18;
    localparam logic [4:0] OUT       = 5'd19;

    logic [4:0]    r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_i0, n_i0;
    logic [KW-1:0] r_i1, n_i1;
    logic [3:0]    r_c, n_c;
    logic [KW-1:0] last_key;
    logic          k_is_last;

    assign last_key  = KW'(i_sts.n - 9'd1);
    assign k_is_last = (9'(r_k) + 9'd1) == i_sts.n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_k     <= '0;
            r_i0    <= '0;
            r_i1    <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i0    <= n_i0;
            r_i1    <= n_i1;
            r_c     <= n_c;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i0    = r_i0;
        n_i1    = r_i1;
        n_c     = r_c;
        o_cmd   = '0;
        o_cmd.chan = r_c;
        case (r_state)
            IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid && i_in_kind == KIND_QUERY) begin
                    n_state = Q_CNT;
                end
            end
            Q_CNT: begin
                n_c = '0;
                if (i_sts.n == 9'd0) begin
                    n_state = OUT;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_key  = 8'(last_key);
                    o_cmd.rd_word = WORD_TIME;
                    n_state       = Q_TOT;
                end
            end
            Q_TOT: begin
                o_cmd.cap_total = 1'b1;
                n_k = '0;
                if (i_sts.loop_en && i_sts.total_pos) begin
                    n_state = M_START;
                end else begin
                    n_state = S_RD;
                end
            end
            M_START: begin
                o_cmd.mod_start = 1'b1;
                n_state = M_WAIT;
            end
            M_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_mod = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_key  = 8'(r_k);
                o_cmd.rd_word = WORD_TIME;
                n_state       = S_CMP;
            end
            S_CMP: begin
                if (i_sts.key_gt || k_is_last) begin
                    if (i_sts.key_gt) begin
                        if (r_k == '0) begin
                            n_i0 = '0;
                            n_i1 = '0;
                        end else begin
                            n_i0 = r_k - KW'(1);
                            n_i1 = r_k;
                        end
                    end else begin
                        n_i0 = last_key;
                        n_i1 = '0;
                    end
                    if (i_sts.t_ge_total && !i_sts.loop_en) begin
                        n_i0 = last_key;
                        n_i1 = last_key;
                    end
                    n_state = R_T0;
                end else begin
                    n_k     = r_k + KW'(1);
                    n_state = S_RD;
                end
            end
            R_T0: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_key  = 8'(r_i0);
                o_cmd.rd_word = WORD_TIME;
                n_state       = R_T1;
            end
            R_T1: begin
                o_cmd.cap_t0  = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_key  = 8'(r_i1);
                o_cmd.rd_word = WORD_TIME;
                n_state       = R_DEC;
            end
            R_DEC: begin
                o_cmd.cap_t1 = 1'b1;
                n_c = '0;
                if (r_i0 == r_i1 || i_sts.t1_le_t0) begin
                    o_cmd.zero_frac = 1'b1;
                    n_state = C_RA;
                end else begin
                    n_state = F_START;
                end
            end
            F_START: begin
                o_cmd.frac_start = 1'b1;
                n_state = F_WAIT;
            end
            F_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_frac = 1'b1;
                    n_state = C_RA;
                end
            end
            C_RA: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_key  = 8'(r_i0);
                o_cmd.rd_word = r_c;
                n_state       = C_RB;
            end
            C_RB: begin
                o_cmd.cap_a   = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_key  = 8'(r_i1);
                o_cmd.rd_word = r_c;
                n_state       = C_MUL;
            end
            C_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = C_ACC;
            end
            C_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_c == CH_LAST) begin
                    n_state = FOC_CHK;
                end else begin
                    n_c     = r_c + 4'd1;
                    n_state = C_RA;
                end
            end
            FOC_CHK: begin
                n_c = '0;
                if (i_sts.sensx_pos) begin
                    o_cmd.foc_mul = 1'b1;
                    n_state = FOC_START;
                end else begin
                    n_state = OUT;
                end
            end
            FOC_START: begin
                o_cmd.foc_start = 1'b1;
                n_state = FOC_WAIT;
            end
            FOC_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_foc = 1'b1;
                    n_state = OUT;
                end
            end
            OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_c == CH_LAST) begin
                        n_state = IDLE;
                    end else begin
                        n_c = r_c + 4'd1;
                    end
                end
            end
            default: begin
                n_state = IDLE;
            end
        endcase
    end

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == IDLE && i_in_valid && i_in_kind == KIND_QUERY) |=> r_state == Q_CNT)
        else $error("query transaction not started");

    a_wrap_then_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_WAIT && i_sts.div_done) |=> (r_state == S_RD && r_k == '0))
        else $error("key search not started after wrap");

    a_out_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && r_c == CH_LAST) |=> r_state == IDLE)
        else $error("sequencer busy after final transaction");

endmodule

`default_nettype wire

// File: design/ckfi_dp.sv
// ----------------------------------------------------------------------------
// ckfi_dp
// key memory, track counts, interpolation arithmetic and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ckfi_dp
    import ckfi_pkg::*;
#(
    parameter int TRACK_COUNT    = 4,
    parameter int KEYS_PER_TRACK = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [1:0]         i_kind,
    input  wire logic [2:0]         i_track,
    input  wire logic [3:0]         i_key_index,
    input  wire logic [3:0]         i_channel,
    input  wire logic signed [31:0] i_word,
    input  wire logic [4:0]         i_key_count,
    input  wire logic signed [31:0] i_query_time,
    input  wire logic [15:0]        i_sensor_width,
    input  wire logic [15:0]        i_sensor_height,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_data,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [3:0]              o_out_channel,
    output logic signed [31:0]      o_out_value,
    output logic                    o_last,
    input  wire t_ckfi_cmd          i_cmd,
    output t_ckfi_sts               o_sts
);

    localparam int TW    = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int KW    = $clog2(KEYS_PER_TRACK);
    localparam int CW    = $clog2(KEYS_PER_TRACK + 1);
    localparam int AW    = TW + KW + 4;
    localparam int DEPTH = 1 << AW;

    logic [31:0]        mem [DEPTH];
    logic [31:0]        r_rdata;
    logic [CW-1:0]      r_counts [TRACK_COUNT];
    logic               r_loop;

    logic signed [31:0] r_t, r_total, r_t0, r_t1, r_a;
    logic [15:0]        r_sw, r_sh;
    logic [TW-1:0]      r_trk;
    logic [CW-1:0]      r_n;
    logic               r_empty;
    logic [16:0]        r_f;
    logic signed [50:0] r_prod;
    logic [31:0]        r_vals [NUM_CHANS];
    logic [47:0]        r_fprod;
    logic               r_fneg;

    logic               r_ov;
    logic [3:0]         r_och;
    logic [31:0]        r_oval;
    logic               r_olast;

    logic               accept;
    logic               wr_ok;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [TW-1:0]      q_trk;
    logic [CW-1:0]      cnt_sat;

    logic               div_start, div_done;
    logic [63:0]        div_dividend, div_quot;
    logic [32:0]        div_divisor, div_rem;
    logic signed [32:0] num, den, diff;
    logic [32:0]        num_pos;
    logic signed [17:0] fs;
    logic signed [50:0] prod_sh;
    logic [31:0]        t_mag, foc_mag;
    logic [31:0]        sat_w, sat_h, out_v;

    assign accept  = i_in_valid && i_cmd.in_ready;
    assign wr_ok   = accept && i_kind == KIND_LOAD && 32'(i_track) < TRACK_COUNT
                     && 32'(i_key_index) < KEYS_PER_TRACK && i_channel <= WORD_TIME;
    assign wr_addr = {TW'(i_track), KW'(i_key_index), i_channel};
    assign rd_addr = {r_trk, i_cmd.rd_key[KW-1:0], i_cmd.rd_word};
    assign q_trk   = (32'(i_track) < TRACK_COUNT) ? TW'(i_track) : '0;
    assign cnt_sat = (32'(i_key_count) > KEYS_PER_TRACK) ? CW'(KEYS_PER_TRACK)
                                                         : CW'(i_key_count);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= i_word;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop <= 1'b0;
            for (int i = 0; i < TRACK_COUNT; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_loop <= i_cfg_data;
            end
            if (accept && i_kind == KIND_COUNT && 32'(i_track) < TRACK_COUNT) begin
                r_counts[TW'(i_track)] <= cnt_sat;
            end
        end
    end

    // arithmetic helpers
    assign t_mag   = r_t[31] ? 32'(-r_t) : r_t;
    assign num     = 33'(r_t) - 33'(r_t0);
    assign num_pos = num[32] ? 33'd0 : num;
    assign den     = 33'(r_t1) - 33'(r_t0);
    assign diff    = 33'($signed(r_rdata)) - 33'(r_a);
    assign fs      = $signed({1'b0, r_f});
    assign prod_sh = r_prod >>> 16;
    assign foc_mag = r_vals[CH_FOCAL][31] ? 32'(-r_vals[CH_FOCAL]) : r_vals[CH_FOCAL];

    assign div_start = i_cmd.mod_start || i_cmd.frac_start || i_cmd.foc_start;
    always_comb begin
        if (i_cmd.mod_start) begin
            div_dividend = {32'd0, t_mag};
            div_divisor  = 33'(r_total);
        end else if (i_cmd.frac_start) begin
            div_dividend = {15'd0, num_pos, 16'd0};
            div_divisor  = den;
        end else begin
            div_dividend = {r_fprod, 16'd0};
            div_divisor  = {2'b00, r_vals[CH_SENSX][30:0]};
        end
    end

    ckfi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_QUERY) begin
            r_t     <= i_query_time;
            r_sw    <= i_sensor_width;
            r_sh    <= i_sensor_height;
            r_trk   <= q_trk;
            r_n     <= r_counts[q_trk];
            r_empty <= r_counts[q_trk] == '0;
        end else if (i_cmd.take_mod) begin
            r_t <= r_t[31] ? 32'(33'd0 - div_rem) : div_rem[31:0];
        end
        if (i_cmd.cap_total) begin
            r_total <= r_rdata;
        end
        if (i_cmd.cap_t0) begin
            r_t0 <= r_rdata;
        end
        if (i_cmd.cap_t1) begin
            r_t1 <= r_rdata;
        end
        if (i_cmd.zero_frac) begin
            r_f <= '0;
        end else if (i_cmd.take_frac) begin
            r_f <= (div_quot > 64'(FRAC_ONE)) ? FRAC_ONE : div_quot[16:0];
        end
        if (i_cmd.cap_a) begin
            r_a <= r_rdata;
        end
        if (i_cmd.mul) begin
            r_prod <= diff * fs;
        end
        if (i_cmd.acc) begin
            r_vals[i_cmd.chan] <= r_a + prod_sh[31:0];
        end
        if (i_cmd.foc_mul) begin
            r_fprod <= 48'(foc_mag) * 48'(r_sw);
            r_fneg  <= r_vals[CH_FOCAL][31];
        end
        if (i_cmd.take_foc) begin
            if (r_fneg) begin
                r_vals[CH_FOCAL] <= (div_quot > 64'h8000_0000) ? 32'h8000_0000
                                                             : 32'(64'd0 - div_quot);
            end else begin
                r_vals[CH_FOCAL] <= (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                             : div_quot[31:0];
            end
        end
    end

    // output register
    assign sat_w = r_sw[15] ? 32'h7FFF_FFFF : {r_sw, 16'd0};
    assign sat_h = r_sh[15] ? 32'h7FFF_FFFF : {r_sh, 16'd0};

    always_comb begin
        if (r_empty) begin
            out_v = '0;
        end else if (i_cmd.chan == CH_SENSX) begin
            out_v = sat_w;
        end else if (i_cmd.chan == CH_SENSY) begin
            out_v = sat_h;
        end else begin
            out_v = r_vals[i_cmd.chan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_och   <= i_cmd.chan;
            r_oval  <= out_v;
            r_olast <= i_cmd.chan == CH_LAST;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_channel = r_och;
    assign o_out_value   = r_oval;
    assign o_last        = r_olast;

    // total time is still on the read data when the wrap is decided
    assign o_sts.n          = 9'(r_n);
    assign o_sts.total_pos  = $signed(r_rdata) > 0;
    assign o_sts.loop_en    = r_loop;
    assign o_sts.t_ge_total = r_t >= r_total;
    assign o_sts.key_gt     = $signed(r_rdata) > r_t;
    assign o_sts.t1_le_t0   = $signed(r_rdata) <= r_t0;
    assign o_sts.div_done   = div_done;
    assign o_sts.sensx_pos  = $signed(r_vals[CH_SENSX]) > 0;
    assign o_sts.out_free   = !r_ov || i_out_ready;

    a_frac_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_frac |=> r_f <= FRAC_ONE)
        else $error("fraction above one");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !i_cmd.out_load)
        else $error("pending result overwritten");

endmodule

`default_nettype wire
